/* design/sum_checked_frame_deframer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sum-checked frame deframer
// Shared wrappers around concurrent assertions clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SUM_CHECKED_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Condition must never be true while out of reset.
`define SCFD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent true implies consequent in the same cycle.
`define SCFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent true implies consequent in the next cycle.
`define SCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/scfd_pkg.sv */
// ----------------------------------------------------------------------------
// scfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package scfd_pkg;

    // Byte counter width (saturating)
    localparam int COUNT_WIDTH = 17;

    // Header layout and byte positions
    localparam logic [COUNT_WIDTH-1:0] HEADER_BYTES = COUNT_WIDTH'(8);
    localparam logic [COUNT_WIDTH-1:0] SUM_SKIP_LO  = COUNT_WIDTH'(6);
    localparam logic [COUNT_WIDTH-1:0] SUM_SKIP_HI  = COUNT_WIDTH'(7);
    localparam logic [COUNT_WIDTH-1:0] WORD_FIRST   = COUNT_WIDTH'(8);
    localparam int HDR_LANES  = 8;
    localparam int WORD_LANES = 4;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Frame queue geometry
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERSION_OPCODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_OPCODE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_VERSION  = 3'd0,
        ST_GRADIENT = 3'd1,
        ST_OTHER    = 3'd2,
        ST_SHORT    = 3'd3,
        ST_LEN_OVER = 3'd4,
        ST_SUM_BAD  = 3'd5
    } status_t;

    // Completed frame as handed from front to back
    typedef struct packed {
        logic [63:0]            hdr;
        logic [15:0]            sum;
        logic [31:0]            word;
        logic [COUNT_WIDTH-1:0] count;
    } frame_rec_t;

endpackage

/* design/scfd_front.sv */
// ----------------------------------------------------------------------------
// scfd_front
// Byte intake: counts bytes, captures header and payload word, keeps the
// running sum, and pushes a frame record on the last byte.
// ----------------------------------------------------------------------------
`include "sum_checked_frame_deframer_top_assert.svh"

module scfd_front
    import scfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        q_full,
    output logic        q_push,
    output frame_rec_t  q_rec
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [63:0]            hdr_reg, hdr_next;
    logic [15:0]            sum_reg, sum_next;
    logic [31:0]            word_reg, word_next;
    logic                   acc;

    // Stall only when the frame queue has no room
    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;

    // Frame state after this byte
    always_comb
    begin
        hdr_next  = hdr_reg;
        word_next = word_reg;
        sum_next  = sum_reg;
        for (int i = 0; i < HDR_LANES; i++)
        begin
            if (count_reg == COUNT_WIDTH'(i))
                hdr_next[8*i +: 8] = in_byte;
        end
        for (int j = 0; j < WORD_LANES; j++)
        begin
            if (count_reg == WORD_FIRST + COUNT_WIDTH'(j))
                word_next[8*j +: 8] = in_byte;
        end
        if (count_reg != SUM_SKIP_LO && count_reg != SUM_SKIP_HI)
            sum_next = sum_reg + {8'd0, in_byte};
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    // Record goes out on the last byte
    assign q_push      = acc && in_last;
    assign q_rec.hdr   = hdr_next;
    assign q_rec.sum   = sum_next;
    assign q_rec.word  = word_next;
    assign q_rec.count = count_next;

    // Frame registers, cleared after each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hdr_reg   <= '0;
            sum_reg   <= '0;
            word_reg  <= '0;
        end
        else if (acc)
        begin
            if (in_last)
            begin
                count_reg <= '0;
                hdr_reg   <= '0;
                sum_reg   <= '0;
                word_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                hdr_reg   <= hdr_next;
                sum_reg   <= sum_next;
                word_reg  <= word_next;
            end
        end
    end

    `SCFD_ASSERT_NEXT(a_clear_after_last, acc && in_last, count_reg == '0, "count not cleared")
    `SCFD_ASSERT_NEXT(a_count_step, acc && !in_last && count_reg != COUNT_MAX,
                      count_reg == $past(count_reg) + 1'b1, "count did not advance")

endmodule

/* design/scfd_queue.sv */
// ----------------------------------------------------------------------------
// scfd_queue
// Short FIFO of completed frame records between intake and classification.
// ----------------------------------------------------------------------------
`include "sum_checked_frame_deframer_top_assert.svh"

module scfd_queue
    import scfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    input  logic       pop,
    output frame_rec_t head_rec,
    output logic       full,
    output logic       empty
);

    frame_rec_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QCNT_W-1:0]       cnt_reg;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_rec = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    `SCFD_ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
    `SCFD_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")

endmodule

/* design/scfd_back.sv */
// ----------------------------------------------------------------------------
// scfd_back
// Classifies the frame at the queue head and holds the result in an output
// register; also holds the two opcode configuration registers.
// ----------------------------------------------------------------------------
`include "sum_checked_frame_deframer_top_assert.svh"

module scfd_back
    import scfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   q_empty,
    input  frame_rec_t             q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output status_t                out_status,
    output logic [15:0]            out_opcode,
    output logic [15:0]            out_reply_opcode,
    output logic [15:0]            out_payload_length,
    output logic [31:0]            out_payload_word
);

    logic [15:0]            version_opcode_reg;
    logic [15:0]            gradient_opcode_reg;
    logic                   valid_reg;
    status_t                status_reg;
    logic [15:0]            opcode_reg, reply_reg, len_reg;
    logic [31:0]            word_reg;
    status_t                status_next;
    logic [15:0]            op, rop, len, chk;
    logic [COUNT_WIDTH-1:0] need;

    assign op   = q_head.hdr[15:0];
    assign rop  = q_head.hdr[31:16];
    assign len  = q_head.hdr[47:32];
    assign chk  = q_head.hdr[63:48];
    assign need = COUNT_WIDTH'(len) + HEADER_BYTES;

    // Status decision, length checks first
    always_comb
    begin
        priority if (q_head.count < HEADER_BYTES)
            status_next = ST_SHORT;
        else if (need > q_head.count)
            status_next = ST_LEN_OVER;
        else if (chk != q_head.sum)
            status_next = ST_SUM_BAD;
        else if (op == version_opcode_reg)
            status_next = ST_VERSION;
        else if (op == gradient_opcode_reg)
            status_next = ST_GRADIENT;
        else
            status_next = ST_OTHER;
    end

    // Load output register when it is empty or being drained
    assign q_pop = !q_empty && (!valid_reg || out_ready);

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_opcode_reg  <= 16'd1;
            gradient_opcode_reg <= 16'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VERSION_OPCODE:  version_opcode_reg  <= cfg_data;
                REG_GRADIENT_OPCODE: gradient_opcode_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            opcode_reg <= op;
            reply_reg  <= rop;
            len_reg    <= len;
            word_reg   <= q_head.word;
        end
    end

    assign out_valid          = valid_reg;
    assign out_status         = status_reg;
    assign out_opcode         = opcode_reg;
    assign out_reply_opcode   = reply_reg;
    assign out_payload_length = len_reg;
    assign out_payload_word   = word_reg;

    `SCFD_ASSERT_NEXT(a_pop_shows, q_pop, out_valid, "popped frame not presented")

endmodule

/* design/sum_checked_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer_top
// Datagram deframer: header capture, 16-bit byte sum check, status result.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; stalls only when the 2-entry frame queue fills.
// Result path: the frame record enters the queue on the edge that accepts the last
//   byte, then is classified into the output register when it is empty or draining.
// Reset: rst_n async low; clears the frame state, queue and output valid,
//   and sets version_opcode = 1, gradient_opcode = 2.
// ----------------------------------------------------------------------------
module sum_checked_frame_deframer_top
    import scfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Byte stream in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  logic                   s_tlast,   // end_of_datagram
    // Result stream out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [79:0]            m_tdata,   // [15:0] opcode, [31:16] reply_opcode,
                                              // [47:32] payload_length, [79:48] payload_word
    output logic [2:0]             m_tuser,   // [2:0] status
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    logic        q_push, q_pop, q_full, q_empty;
    frame_rec_t  q_in_rec, q_head_rec;
    status_t     res_status;
    logic [15:0] res_opcode, res_reply, res_len;
    logic [31:0] res_word;

    assign cfg_ready = 1'b1;

    // Intake
    scfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (q_in_rec)
    );

    // Frame queue
    scfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_in_rec),
        .pop      (q_pop),
        .head_rec (q_head_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Classification and output
    scfd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .q_empty            (q_empty),
        .q_head             (q_head_rec),
        .q_pop              (q_pop),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_status         (res_status),
        .out_opcode         (res_opcode),
        .out_reply_opcode   (res_reply),
        .out_payload_length (res_len),
        .out_payload_word   (res_word)
    );

    assign m_tdata = {res_word, res_len, res_reply, res_opcode};
    assign m_tuser = res_status;

endmodule
